FILE: rtl/core/i2cws_pkg.sv
// shared constants, codes and word types of the i2c write/read sequencer
package i2cws_pkg;

  // buffer geometry
  localparam int BUF_DEPTH = 32;
  localparam int IDX_W     = $clog2(BUF_DEPTH);
  localparam int CNT_W     = $clog2(BUF_DEPTH + 1);

  // input opcodes
  localparam logic [3:0] OP_LOAD     = 4'd0;
  localparam logic [3:0] OP_START    = 4'd1;
  localparam logic [3:0] OP_NACK     = 4'd2;
  localparam logic [3:0] OP_RX       = 4'd3;
  localparam logic [3:0] OP_TX       = 4'd4;
  localparam logic [3:0] OP_COMPLETE = 4'd5;
  localparam logic [3:0] OP_STOP     = 4'd6;
  localparam logic [3:0] OP_FAULT    = 4'd7;
  localparam logic [3:0] OP_READ     = 4'd8;

  // commands to the byte engine
  localparam logic [2:0] CMD_NONE     = 3'd0;
  localparam logic [2:0] CMD_START_WR = 3'd1;
  localparam logic [2:0] CMD_START_RD = 3'd2;
  localparam logic [2:0] CMD_SEND     = 3'd3;
  localparam logic [2:0] CMD_QUIESCE  = 3'd4;
  localparam logic [2:0] CMD_DISABLE  = 3'd5;

  // start request outcomes
  localparam logic [1:0] SRES_OK    = 2'd0;
  localparam logic [1:0] SRES_BUSY  = 2'd1;
  localparam logic [1:0] SRES_ERROR = 2'd2;

  // status flag bit positions
  localparam int FL_BUSY  = 0;
  localparam int FL_WRITE = 1;
  localparam int FL_READ  = 2;
  localparam int FL_READY = 3;
  localparam int FL_ERROR = 4;
  localparam int FL_NACK  = 5;

  // byte sent when the transmitter runs past the buffer
  localparam logic [7:0] IDLE_BYTE = 8'hFF;

  // one input word
  typedef struct packed {
    logic [3:0]       opcode;
    logic [6:0]       slave_addr;
    logic             wr_present;
    logic [CNT_W-1:0] wr_count;
    logic             rd_present;
    logic [CNT_W-1:0] rd_count;
    logic             bus_busy;
    logic             bus_fault;
    logic [4:0]       buf_index;
    logic [7:0]       byte_in;
  } item_t;

  // one result word
  typedef struct packed {
    logic [5:0]       status_flags;
    logic [2:0]       command;
    logic [6:0]       cmd_addr;
    logic [CNT_W-1:0] cmd_count;
    logic             cmd_autoend;
    logic [7:0]       byte_out;
    logic [1:0]       start_result;
    logic [CNT_W-1:0] sent_count;
  } result_t;

endpackage

FILE: rtl/core/i2cws_ctrl.sv
// transaction state, data buffer and per-word decision logic
module i2cws_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  i2cws_pkg::item_t  item,
  output i2cws_pkg::result_t result
);
  import i2cws_pkg::*;

  logic [6:0]       addr_r, addr_nxt;
  logic [5:0]       flag_r, flag_nxt;
  logic [CNT_W-1:0] wtot_r, wtot_nxt;
  logic [CNT_W-1:0] rtot_r, rtot_nxt;
  logic [CNT_W-1:0] ptr_r, ptr_nxt;
  logic             rx_en_r, rx_en_nxt;
  logic             tx_en_r, tx_en_nxt;
  logic [7:0]       buf_r [BUF_DEPTH];

  logic             buf_we;
  logic [IDX_W-1:0] buf_wa;
  logic [IDX_W-1:0] buf_ra;
  logic [7:0]       buf_rd;
  logic             ptr_ok;
  logic             idx_ok;
  logic             do_read;
  logic             do_finish;
  logic [5:0]       fin_flags;

  // single buffer read port: pointer for tx, index otherwise
  assign ptr_ok = (ptr_r < CNT_W'(BUF_DEPTH));
  assign idx_ok = (32'(item.buf_index) < BUF_DEPTH);
  assign buf_ra = (item.opcode == OP_TX) ? ptr_r[IDX_W-1:0] : IDX_W'(item.buf_index);
  assign buf_rd = buf_r[buf_ra];

  // decode the word and form next state and result
  always_comb begin
    addr_nxt  = addr_r;
    flag_nxt  = flag_r;
    wtot_nxt  = wtot_r;
    rtot_nxt  = rtot_r;
    ptr_nxt   = ptr_r;
    rx_en_nxt = rx_en_r;
    tx_en_nxt = tx_en_r;
    buf_we    = 1'b0;
    buf_wa    = IDX_W'(item.buf_index);
    do_read   = 1'b0;
    do_finish = 1'b0;
    fin_flags = '0;
    result    = '0;
    result.command      = CMD_NONE;
    result.start_result = SRES_OK;

    unique case (item.opcode)
      OP_LOAD: begin
        buf_we = idx_ok;
      end
      OP_START: begin
        if (item.bus_fault) begin
          flag_nxt[FL_ERROR]  = 1'b1;
          result.command      = CMD_DISABLE;
          result.start_result = SRES_ERROR;
        end else if (item.bus_busy) begin
          result.start_result = SRES_BUSY;
        end else begin
          addr_nxt  = item.slave_addr;
          ptr_nxt   = '0;
          wtot_nxt  = '0;
          rtot_nxt  = '0;
          if (item.wr_present) begin
            wtot_nxt = (item.wr_count > CNT_W'(BUF_DEPTH)) ? CNT_W'(BUF_DEPTH) : item.wr_count;
          end
          if (item.rd_present) begin
            rtot_nxt = (item.rd_count > CNT_W'(BUF_DEPTH)) ? CNT_W'(BUF_DEPTH) : item.rd_count;
          end
          flag_nxt           = '0;
          flag_nxt[FL_BUSY]  = 1'b1;
          flag_nxt[FL_WRITE] = item.wr_present;
          flag_nxt[FL_READ]  = item.rd_present;
          rx_en_nxt = 1'b0;
          tx_en_nxt = 1'b0;
          if (item.wr_present) begin
            result.command     = CMD_START_WR;
            result.cmd_addr    = item.slave_addr;
            result.cmd_count   = wtot_nxt;
            result.cmd_autoend = ~item.rd_present;
            tx_en_nxt          = (wtot_nxt != '0);
          end else begin
            do_read = 1'b1;
          end
        end
      end
      OP_NACK: begin
        if (ptr_r == '0) begin
          do_finish = 1'b1;
          fin_flags[FL_NACK] = 1'b1;
        end else if (flag_r[FL_WRITE]) begin
          wtot_nxt = ptr_r;
          if (flag_r[FL_READ]) begin
            do_read = 1'b1;
          end else begin
            do_finish = 1'b1;
            fin_flags[FL_READY] = 1'b1;
          end
        end
      end
      OP_RX: begin
        if (rx_en_r) begin
          if (ptr_ok) begin
            buf_we  = 1'b1;
            buf_wa  = ptr_r[IDX_W-1:0];
            ptr_nxt = ptr_r + CNT_W'(1);
          end
          if (ptr_nxt >= rtot_r) begin
            do_finish = 1'b1;
            fin_flags[FL_READY] = 1'b1;
          end
        end
      end
      OP_TX: begin
        if (tx_en_r) begin
          result.command = CMD_SEND;
          if (ptr_ok) begin
            result.byte_out = buf_rd;
            ptr_nxt         = ptr_r + CNT_W'(1);
          end else begin
            result.byte_out = IDLE_BYTE;
          end
        end
      end
      OP_COMPLETE: begin
        do_read = 1'b1;
      end
      OP_STOP: begin
        do_finish = 1'b1;
        fin_flags[FL_READY] = 1'b1;
      end
      OP_FAULT: begin
        flag_nxt[FL_ERROR] = 1'b1;
        result.command     = CMD_DISABLE;
      end
      OP_READ: begin
        if (idx_ok) begin
          result.byte_out = buf_rd;
        end
      end
      default: begin
      end
    endcase

    // read phase start: repeated start with autoend
    if (do_read) begin
      result.command     = CMD_START_RD;
      result.cmd_addr    = addr_nxt;
      result.cmd_count   = (rtot_nxt == '0) ? CNT_W'(1) : rtot_nxt;
      result.cmd_autoend = 1'b1;
      rx_en_nxt = 1'b1;
      tx_en_nxt = 1'b0;
      ptr_nxt   = '0;
    end

    // end of transaction
    if (do_finish) begin
      result.command = CMD_QUIESCE;
      rx_en_nxt = 1'b0;
      tx_en_nxt = 1'b0;
      flag_nxt  = fin_flags;
    end

    result.status_flags = flag_nxt;
    result.sent_count   = wtot_nxt;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r  <= '0;
      flag_r  <= '0;
      wtot_r  <= '0;
      rtot_r  <= '0;
      ptr_r   <= '0;
      rx_en_r <= 1'b0;
      tx_en_r <= 1'b0;
    end else if (step) begin
      addr_r  <= addr_nxt;
      flag_r  <= flag_nxt;
      wtot_r  <= wtot_nxt;
      rtot_r  <= rtot_nxt;
      ptr_r   <= ptr_nxt;
      rx_en_r <= rx_en_nxt;
      tx_en_r <= tx_en_nxt;
    end
  end

  // data buffer
  always_ff @(posedge clk) begin
    if (step && buf_we) begin
      buf_r[buf_wa] <= item.byte_in;
    end
  end

  // receiver and transmitter are never on together
  assert property (@(posedge clk) disable iff (!rst_n) !(rx_en_r && tx_en_r))
    else $error("rx and tx enabled together");

  // pointer and transfer counts stay within the buffer plus one
  assert property (@(posedge clk) disable iff (!rst_n)
    (ptr_r <= CNT_W'(BUF_DEPTH)) && (wtot_r <= CNT_W'(BUF_DEPTH))
      && (rtot_r <= CNT_W'(BUF_DEPTH)))
    else $error("pointer or count beyond buffer depth");

  // a read start never asks for zero bytes
  assert property (@(posedge clk) disable iff (!rst_n)
    (result.command == CMD_START_RD) |-> (result.cmd_count != '0))
    else $error("read start with zero count");

  // a disable command leaves the error flag set
  assert property (@(posedge clk) disable iff (!rst_n)
    (step && result.command == CMD_DISABLE) |=> flag_r[FL_ERROR])
    else $error("disable without error flag");

  // an accepted start brings the busy flag up
  assert property (@(posedge clk) disable iff (!rst_n)
    (step && item.opcode == OP_START && !item.bus_fault && !item.bus_busy)
      |=> (flag_r[FL_BUSY] && ptr_r == '0))
    else $error("start did not set busy");

endmodule

FILE: rtl/core/i2c_write_read_sequencer.sv
// top level of the i2c write/read sequencer: input and result registers
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  opcode, address, counts, index, byte
//   out_     output     out_valid/out_stall flags, command, data, counts
//
// one word per cycle sustained while out_stall is low; a word goes from
// the input register through the decision logic to the result register
// the transaction state loop closes within the control unit
// rst_n is synchronous; it clears control state, the buffer is not cleared
// out_stall holds the result register and backs up into in_stall
module i2c_write_read_sequencer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [3:0]                  in_opcode,
  input  logic [6:0]                  in_slave_addr,
  input  logic                        in_wr_present,
  input  logic [i2cws_pkg::CNT_W-1:0] in_wr_count,
  input  logic                        in_rd_present,
  input  logic [i2cws_pkg::CNT_W-1:0] in_rd_count,
  input  logic                        in_bus_busy,
  input  logic                        in_bus_fault,
  input  logic [4:0]                  in_buf_index,
  input  logic [7:0]                  in_byte_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [5:0]                  out_status_flags,
  output logic [2:0]                  out_command,
  output logic [6:0]                  out_cmd_addr,
  output logic [i2cws_pkg::CNT_W-1:0] out_cmd_count,
  output logic                        out_cmd_autoend,
  output logic [7:0]                  out_byte_out,
  output logic [1:0]                  out_start_result,
  output logic [i2cws_pkg::CNT_W-1:0] out_sent_count
);
  import i2cws_pkg::*;

  logic    in_valid_r;
  item_t   item_r;
  logic    out_valid_r;
  result_t res_r;
  result_t res;
  logic    out_adv;
  logic    step;

  // pipeline advance
  assign out_adv  = !out_valid_r || !out_stall;
  assign step     = in_valid_r && out_adv;
  assign in_stall = in_valid_r && !out_adv;

  // input word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r.opcode     <= in_opcode;
      item_r.slave_addr <= in_slave_addr;
      item_r.wr_present <= in_wr_present;
      item_r.wr_count   <= in_wr_count;
      item_r.rd_present <= in_rd_present;
      item_r.rd_count   <= in_rd_count;
      item_r.bus_busy   <= in_bus_busy;
      item_r.bus_fault  <= in_bus_fault;
      item_r.buf_index  <= in_buf_index;
      item_r.byte_in    <= in_byte_in;
    end
  end

  // decision logic and transaction state
  i2cws_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (item_r),
    .result (res)
  );

  // result word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status_flags = res_r.status_flags;
  assign out_command      = res_r.command;
  assign out_cmd_addr     = res_r.cmd_addr;
  assign out_cmd_count    = res_r.cmd_count;
  assign out_cmd_autoend  = res_r.cmd_autoend;
  assign out_byte_out     = res_r.byte_out;
  assign out_start_result = res_r.start_result;
  assign out_sent_count   = res_r.sent_count;

endmodule
